FILE: design/spot_cone_intensity_top_macros.svh
// ----------------------------------------------------------------------------
// Spot cone intensity assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef SPOT_CONE_INTENSITY_TOP_MACROS_SVH
`define SPOT_CONE_INTENSITY_TOP_MACROS_SVH

// check under reset qualification
`define SCI_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("sci port check failed");

// check that also holds through reset
`define SCI_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("sci reset check failed");

`endif

FILE: design/sci_pkg.sv
// ----------------------------------------------------------------------------
// Spot cone intensity package
// Widths, register indexes and sideband types shared by the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sci_pkg;

    localparam int VEC_W   = 24;
    localparam int OFF_W   = 25;
    localparam int DIR_W   = 16;
    localparam int SQ_W    = 48;
    localparam int L2_W    = 50;
    localparam int PROD_W  = 41;
    localparam int DOT_W   = 43;
    localparam int ADOT_W  = 42;
    localparam int K_W     = 5;
    localparam int SQN_W   = 62;
    localparam int SQ_STEPS = 31;
    localparam int ROOT_W  = 31;
    localparam int NUM_W   = 74;
    localparam int Q1_W    = 20;
    localparam int TH_W    = 21;
    localparam int CO_W    = 18;
    localparam int EPS_W   = 19;
    localparam int FN_W    = 22;
    localparam int D2_W    = 18;
    localparam int Q2_W    = 16;
    localparam int INT_W   = 17;
    localparam int RANGE_W = 23;
    localparam int R2_W    = 46;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W   = 48;

    localparam logic [INT_W-1:0] FULL_SCALE = 17'h10000;

    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_POS_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_POS_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_POS_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPOT_DIR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COS_INNER   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COS_OUTER   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_RANGE = 3'd6;

    typedef struct packed {
        logic              neg;
        logic [ADOT_W-1:0] adot;
        logic [K_W-1:0]    k;
        logic              zero;
        logic              in_range;
    } t_side;

    typedef struct packed {
        logic [INT_W-1:0] fixed;
        logic             use_div;
        logic             in_cone;
    } t_fall;

endpackage

`default_nettype wire

FILE: design/sci_front.sv
// ----------------------------------------------------------------------------
// Spot cone intensity front end
// Offset, squares, dot product, range test and normalisation shift.
// ----------------------------------------------------------------------------
`default_nettype none

module sci_front (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  wire logic                              i_valid,
    input  wire logic                              i_op,
    input  wire logic signed [sci_pkg::VEC_W-1:0]  i_vec_x,
    input  wire logic signed [sci_pkg::VEC_W-1:0]  i_vec_y,
    input  wire logic signed [sci_pkg::VEC_W-1:0]  i_vec_z,
    input  wire logic signed [sci_pkg::VEC_W-1:0]  i_lp_x,
    input  wire logic signed [sci_pkg::VEC_W-1:0]  i_lp_y,
    input  wire logic signed [sci_pkg::VEC_W-1:0]  i_lp_z,
    input  wire logic [3*sci_pkg::DIR_W-1:0]       i_dir,
    input  wire logic [sci_pkg::R2_W-1:0]          i_r2,
    output logic                                   o_valid,
    output logic [sci_pkg::SQN_W-1:0]              o_n,
    output sci_pkg::t_side                         o_side
);
    import sci_pkg::*;

    logic [4:0] r_vld;

    logic signed [OFF_W-1:0]  r1_v [3];
    logic signed [OFF_W-1:0]  n1_v [3];
    logic [SQ_W-1:0]          r2_sq [3];
    logic signed [PROD_W-1:0] r2_p [3];
    logic [SQ_W-1:0]          n2_sq [3];
    logic signed [PROD_W-1:0] n2_p [3];
    logic [OFF_W-1:0]         w_abs [3];
    logic signed [DIR_W-1:0]  w_dir [3];
    logic [L2_W-1:0]          r3_l2;
    logic signed [DOT_W-1:0]  r3_dot;
    logic [L2_W-1:0]          r4_l2;
    t_side                    r4_side;
    t_side                    n4_side;
    logic [5:0]               w_h;
    logic [6:0]               w_kt;
    logic [SQN_W-1:0]         r5_n;
    t_side                    r5_side;
    logic signed [VEC_W-1:0]  w_vec [3];
    logic signed [VEC_W-1:0]  w_lp [3];

    assign w_vec[0] = i_vec_x;
    assign w_vec[1] = i_vec_y;
    assign w_vec[2] = i_vec_z;
    assign w_lp[0]  = i_lp_x;
    assign w_lp[1]  = i_lp_y;
    assign w_lp[2]  = i_lp_z;
    assign w_dir[0] = i_dir[15:0];
    assign w_dir[1] = i_dir[31:16];
    assign w_dir[2] = i_dir[47:32];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_v[i] = OFF_W'(w_vec[i]) - (i_op ? OFF_W'(w_lp[i]) : '0);
            w_abs[i] = r1_v[i][OFF_W-1] ? OFF_W'(-r1_v[i]) : OFF_W'(r1_v[i]);
            n2_sq[i] = w_abs[i][VEC_W-1:0] * w_abs[i][VEC_W-1:0];
            n2_p[i]  = r1_v[i] * w_dir[i];
        end
    end

    always_comb begin
        w_h = '0;
        for (int i = 0; i < L2_W; i++) begin
            if (r3_l2[i]) begin
                w_h = 6'(i);
            end
        end
        w_kt = 7'd61 - {1'b0, w_h};
        n4_side.k        = w_kt[5:1];
        n4_side.zero     = (r3_l2 == '0);
        n4_side.in_range = (r3_l2 <= L2_W'(i_r2));
        n4_side.neg      = r3_dot[DOT_W-1];
        n4_side.adot     = r3_dot[DOT_W-1] ? ADOT_W'(-r3_dot) : ADOT_W'(r3_dot);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_v    <= n1_v;
            r2_sq   <= n2_sq;
            r2_p    <= n2_p;
            r3_l2   <= L2_W'(r2_sq[0]) + L2_W'(r2_sq[1]) + L2_W'(r2_sq[2]);
            r3_dot  <= DOT_W'(r2_p[0]) + DOT_W'(r2_p[1]) + DOT_W'(r2_p[2]);
            r4_l2   <= r3_l2;
            r4_side <= n4_side;
            r5_n    <= SQN_W'(r4_l2) << {r4_side.k, 1'b0};
            r5_side <= r4_side;
        end
    end

    assign o_valid = r_vld[4];
    assign o_n     = r5_n;
    assign o_side  = r5_side;

endmodule

`default_nettype wire

FILE: design/sci_sqrt_step.sv
// ----------------------------------------------------------------------------
// Spot cone intensity root step
// One registered digit of the integer square root.
// ----------------------------------------------------------------------------
`default_nettype none

module sci_sqrt_step #(
    parameter int STEP = 0
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [sci_pkg::SQN_W-1:0]     i_n,
    input  wire logic [sci_pkg::SQN_W-1:0]     i_r,
    output logic [sci_pkg::SQN_W-1:0]          o_n,
    output logic [sci_pkg::SQN_W-1:0]          o_r
);
    import sci_pkg::*;

    localparam logic [SQN_W:0] BIT = (SQN_W+1)'(1) << (2 * STEP);

    logic [SQN_W:0]   w_sum;
    logic [SQN_W-1:0] n_n;
    logic [SQN_W-1:0] n_r;

    always_comb begin
        w_sum = {1'b0, i_r} + BIT;
        if ({1'b0, i_n} >= w_sum) begin
            n_n = i_n - w_sum[SQN_W-1:0];
            n_r = (i_r >> 1) + BIT[SQN_W-1:0];
        end else begin
            n_n = i_n;
            n_r = i_r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_n <= n_n;
            o_r <= n_r;
        end
    end

endmodule

`default_nettype wire

FILE: design/sci_div_step.sv
// ----------------------------------------------------------------------------
// Spot cone intensity divide step
// One registered quotient bit of a restoring division.
// ----------------------------------------------------------------------------
`default_nettype none

module sci_div_step #(
    parameter int DW = 31,
    parameter int NW = 20,
    parameter int QW = 20
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [DW-1:0] i_rem,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_d,
    input  wire logic [QW-1:0] i_q,
    output logic [DW-1:0]      o_rem,
    output logic [NW-1:0]      o_num,
    output logic [DW-1:0]      o_d,
    output logic [QW-1:0]      o_q
);
    logic [DW:0]   w_t;
    logic [DW:0]   w_diff;
    logic          w_ge;

    always_comb begin
        w_t    = {i_rem, i_num[NW-1]};
        w_ge   = (w_t >= {1'b0, i_d});
        w_diff = w_t - {1'b0, i_d};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem <= w_ge ? w_diff[DW-1:0] : w_t[DW-1:0];
            o_num <= i_num << 1;
            o_d   <= i_d;
            o_q   <= {i_q[QW-2:0], w_ge};
        end
    end

endmodule

`default_nettype wire

FILE: design/spot_cone_intensity_top.sv
// ----------------------------------------------------------------------------
// Spot cone intensity top level
// Smooth spotlight cone falloff and in-cone flag, one vector per cycle when unstalled.
// ----------------------------------------------------------------------------
// channel | dir | tdata / data                   | tuser
// s_axis  | in  | vec_x, vec_y, vec_z            | op
// m_axis  | out | intensity                      | in_cone
// cfg     | in  | register index, write data     | -
//
// One request accepted per cycle unless the output stalls; the pipeline runs through
// the 31-step square root, the 20-step theta divider and the 16-step falloff divider.
// Reset is synchronous, active low, clears every valid bit and restores the
// configuration registers.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module spot_cone_intensity_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    input  wire logic [71:0]                        i_s_axis_tdata,  // vec_x, vec_y, vec_z
    input  wire logic                               i_s_axis_tuser,  // op
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    output logic [23:0]                             o_m_axis_tdata,  // intensity
    output logic                                    o_m_axis_tuser,  // in_cone
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [sci_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [sci_pkg::CFG_W-1:0]          i_cfg_data
);
    import sci_pkg::*;

    logic w_en;

    logic signed [VEC_W-1:0]   r_lp_x, r_lp_y, r_lp_z;
    logic [3*DIR_W-1:0]        r_dir;
    logic signed [DIR_W-1:0]   r_cos_in, r_cos_out;
    logic [RANGE_W-1:0]        r_range;
    logic [R2_W-1:0]           r_r2;
    logic signed [CO_W-1:0]    r_co16;
    logic signed [EPS_W-1:0]   r_eps16;

    logic                      w_f_vld;
    logic [SQN_W-1:0]          w_f_n;
    t_side                     w_f_side;

    logic [SQN_W-1:0]          w_sn [SQ_STEPS+1];
    logic [SQN_W-1:0]          w_sr [SQ_STEPS+1];
    t_side                     r_sside [SQ_STEPS];
    logic [SQ_STEPS-1:0]       r_svld;

    logic [NUM_W-1:0]          w_pn;
    logic [ROOT_W-1:0]         r_p_rem;
    logic [Q1_W-1:0]           r_p_num;
    logic [ROOT_W-1:0]         r_p_d;
    t_side                     r_p_side;
    logic                      r_p_vld;

    logic [ROOT_W-1:0]         w_d1rem [Q1_W+1];
    logic [Q1_W-1:0]           w_d1num [Q1_W+1];
    logic [ROOT_W-1:0]         w_d1d   [Q1_W+1];
    logic [Q1_W-1:0]           w_d1q   [Q1_W+1];
    t_side                     r_d1side [Q1_W];
    logic [Q1_W-1:0]           r_d1vld;

    logic signed [TH_W-1:0]    w_theta;
    logic signed [FN_W-1:0]    w_fnum;
    logic signed [FN_W-1:0]    w_co_x;
    logic signed [FN_W-1:0]    w_eps_x;
    logic                      w_above;
    t_side                     w_ls;
    t_fall                     n_f_fall;
    logic [D2_W-1:0]           n_f_rem;
    logic [D2_W-1:0]           r_f_rem;
    logic [D2_W-1:0]           r_f_d;
    t_fall                     r_f_fall;
    logic                      r_f_vld;

    logic [D2_W-1:0]           w_d2rem [Q2_W+1];
    logic [Q2_W-1:0]           w_d2num [Q2_W+1];
    logic [D2_W-1:0]           w_d2d   [Q2_W+1];
    logic [Q2_W-1:0]           w_d2q   [Q2_W+1];
    t_fall                     r_d2fall [Q2_W];
    logic [Q2_W-1:0]           r_d2vld;

    logic                      r_out_valid;
    logic [INT_W-1:0]          r_out_int;
    logic                      r_out_cone;

    assign w_en            = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_cfg_ready     = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp_x    <= '0;
            r_lp_y    <= '0;
            r_lp_z    <= '0;
            r_dir     <= 48'd3221291008;
            r_cos_in  <= 16'sd15985;
            r_cos_out <= 16'sd15624;
            r_range   <= 23'd102400;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_LIGHT_POS_X: r_lp_x    <= i_cfg_data[VEC_W-1:0];
                REG_LIGHT_POS_Y: r_lp_y    <= i_cfg_data[VEC_W-1:0];
                REG_LIGHT_POS_Z: r_lp_z    <= i_cfg_data[VEC_W-1:0];
                REG_SPOT_DIR:    r_dir     <= i_cfg_data;
                REG_COS_INNER:   r_cos_in  <= i_cfg_data[DIR_W-1:0];
                REG_COS_OUTER:   r_cos_out <= i_cfg_data[DIR_W-1:0];
                REG_LIGHT_RANGE: r_range   <= i_cfg_data[RANGE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_r2    <= r_range * r_range;
        r_co16  <= CO_W'(r_cos_out) <<< 2;
        r_eps16 <= (EPS_W'(r_cos_in) - EPS_W'(r_cos_out)) <<< 2;
    end

    sci_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_axis_tvalid),
        .i_op    (i_s_axis_tuser),
        .i_vec_x (i_s_axis_tdata[23:0]),
        .i_vec_y (i_s_axis_tdata[47:24]),
        .i_vec_z (i_s_axis_tdata[71:48]),
        .i_lp_x  (r_lp_x),
        .i_lp_y  (r_lp_y),
        .i_lp_z  (r_lp_z),
        .i_dir   (r_dir),
        .i_r2    (r_r2),
        .o_valid (w_f_vld),
        .o_n     (w_f_n),
        .o_side  (w_f_side)
    );

    // square root pipeline
    assign w_sn[0] = w_f_n;
    assign w_sr[0] = '0;

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
        sci_sqrt_step #(.STEP(SQ_STEPS - 1 - g)) u_step (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_n   (w_sn[g]),
            .i_r   (w_sr[g]),
            .o_n   (w_sn[g+1]),
            .o_r   (w_sr[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sside[0] <= w_f_side;
            for (int i = 1; i < SQ_STEPS; i++) begin
                r_sside[i] <= r_sside[i-1];
            end
        end
    end

    // theta divider set-up
    assign w_pn = NUM_W'(r_sside[SQ_STEPS-1].adot) << (6'(r_sside[SQ_STEPS-1].k) + 6'd2);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_rem  <= w_pn[Q1_W+ROOT_W-1:Q1_W];
            r_p_num  <= w_pn[Q1_W-1:0];
            r_p_d    <= w_sr[SQ_STEPS][ROOT_W-1:0];
            r_p_side <= r_sside[SQ_STEPS-1];
        end
    end

    assign w_d1rem[0] = r_p_rem;
    assign w_d1num[0] = r_p_num;
    assign w_d1d[0]   = r_p_d;
    assign w_d1q[0]   = '0;

    for (genvar g = 0; g < Q1_W; g++) begin : g_div1
        sci_div_step #(.DW(ROOT_W), .NW(Q1_W), .QW(Q1_W)) u_step (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_rem (w_d1rem[g]),
            .i_num (w_d1num[g]),
            .i_d   (w_d1d[g]),
            .i_q   (w_d1q[g]),
            .o_rem (w_d1rem[g+1]),
            .o_num (w_d1num[g+1]),
            .o_d   (w_d1d[g+1]),
            .o_q   (w_d1q[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d1side[0] <= r_p_side;
            for (int i = 1; i < Q1_W; i++) begin
                r_d1side[i] <= r_d1side[i-1];
            end
        end
    end

    // falloff decision
    always_comb begin
        w_ls    = r_d1side[Q1_W-1];
        w_theta = w_ls.neg ? -TH_W'({1'b0, w_d1q[Q1_W]}) : TH_W'({1'b0, w_d1q[Q1_W]});
        w_co_x  = FN_W'(r_co16);
        w_eps_x = FN_W'(r_eps16);
        w_fnum  = FN_W'(w_theta) - w_co_x;
        w_above = FN_W'(w_theta) > w_co_x;
        n_f_rem = w_fnum[D2_W-1:0];
        n_f_fall.use_div = 1'b0;
        n_f_fall.fixed   = '0;
        n_f_fall.in_cone = w_ls.in_range && w_above && !w_ls.zero;
        if (w_ls.zero) begin
            n_f_fall.fixed = '0;
        end else if (w_eps_x <= 0) begin
            n_f_fall.fixed = w_above ? FULL_SCALE : '0;
        end else if (w_fnum <= 0) begin
            n_f_fall.fixed = '0;
        end else if (w_fnum >= w_eps_x) begin
            n_f_fall.fixed = FULL_SCALE;
        end else begin
            n_f_fall.use_div = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_rem  <= n_f_rem;
            r_f_d    <= r_eps16[D2_W-1:0];
            r_f_fall <= n_f_fall;
        end
    end

    assign w_d2rem[0] = r_f_rem;
    assign w_d2num[0] = '0;
    assign w_d2d[0]   = r_f_d;
    assign w_d2q[0]   = '0;

    for (genvar g = 0; g < Q2_W; g++) begin : g_div2
        sci_div_step #(.DW(D2_W), .NW(Q2_W), .QW(Q2_W)) u_step (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_rem (w_d2rem[g]),
            .i_num (w_d2num[g]),
            .i_d   (w_d2d[g]),
            .i_q   (w_d2q[g]),
            .o_rem (w_d2rem[g+1]),
            .o_num (w_d2num[g+1]),
            .o_d   (w_d2d[g+1]),
            .o_q   (w_d2q[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d2fall[0] <= r_f_fall;
            for (int i = 1; i < Q2_W; i++) begin
                r_d2fall[i] <= r_d2fall[i-1];
            end
            r_out_int  <= r_d2fall[Q2_W-1].use_div ? INT_W'(w_d2q[Q2_W])
                                                   : r_d2fall[Q2_W-1].fixed;
            r_out_cone <= r_d2fall[Q2_W-1].in_cone;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_svld      <= '0;
            r_p_vld     <= 1'b0;
            r_d1vld     <= '0;
            r_f_vld     <= 1'b0;
            r_d2vld     <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_svld      <= {r_svld[SQ_STEPS-2:0], w_f_vld};
            r_p_vld     <= r_svld[SQ_STEPS-1];
            r_d1vld     <= {r_d1vld[Q1_W-2:0], r_p_vld};
            r_f_vld     <= r_d1vld[Q1_W-1];
            r_d2vld     <= {r_d2vld[Q2_W-2:0], r_f_vld};
            r_out_valid <= r_d2vld[Q2_W-1];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'b0, r_out_int};
    assign o_m_axis_tuser  = r_out_cone;

endmodule

`default_nettype wire

FILE: design/sci_chk.sv
// ----------------------------------------------------------------------------
// Spot cone intensity port checker
// Port-level properties of the top level, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "spot_cone_intensity_top_macros.svh"

module sci_chk (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    input  wire logic        o_s_axis_tready,
    input  wire logic [71:0] i_s_axis_tdata,
    input  wire logic        i_s_axis_tuser,
    input  wire logic        o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    input  wire logic [23:0] o_m_axis_tdata,
    input  wire logic        o_m_axis_tuser,
    input  wire logic        i_cfg_valid,
    input  wire logic        o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [47:0] i_cfg_data
);

    `SCI_ASSERT(a_hold_stalled, $past(i_rst_n) && $past(o_m_axis_tvalid && !i_m_axis_tready) |-> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
    `SCI_ASSERT(a_full_scale, o_m_axis_tvalid |-> (o_m_axis_tdata[23:17] == 7'd0) && (o_m_axis_tdata[16] == 1'b0 || o_m_axis_tdata[15:0] == 16'd0))
    `SCI_ASSERT(a_ready_follows, i_m_axis_tready |-> o_s_axis_tready && o_cfg_ready)
    `SCI_ASSERT_RST(a_reset_empty, !i_rst_n |=> !o_m_axis_tvalid)

endmodule

bind spot_cone_intensity_top sci_chk u_sci_chk (.*);

`default_nettype wire

FILE: bench/tb_spot_cone_intensity_top.sv
// ----------------------------------------------------------------------------
// Spot cone intensity testbench
// Streams offset and world-point vectors through the block under several
// light settings, including degenerate cones, zero range and non-unit
// directions, and checks intensity and in-cone flag against a local model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_spot_cone_intensity_top;
    import sci_pkg::*;

    typedef struct {
        logic [INT_W-1:0] inten;
        logic             cone;
    } t_cone_res;

    typedef struct {
        bit          op;
        logic [23:0] x, y, z;
        bit          typed;
        logic [16:0] inten;
        bit          cone;
    } t_stim_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_valid = 1'b0;
    logic [71:0]       s_data = '0;
    logic              s_user = 1'b0;
    logic              m_ready = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data = '0;
    wire               s_ready, m_valid, m_user, cfg_ready;
    wire  [23:0]       m_data;

    spot_cone_intensity_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data), .i_s_axis_tuser(s_user),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data), .o_m_axis_tuser(m_user),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // light settings as seen by the model
    logic signed [23:0] light_pos [3];
    logic [47:0]        spot_dir;
    logic signed [15:0] cos_in, cos_out;
    logic [22:0]        lit_range;

    t_cone_res   cone_expect_q [$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          items_sent = 0;
    int          stall_pct = 0;
    int          hold_tickets = 0;
    int          hold_served = 0;
    int          hold_cnt = 0;
    int          burst_left = 0;

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_cone_res cone_falloff(bit op, logic [23:0] x, logic [23:0] y,
                                               logic [23:0] z);
        longint v [3];
        longint d [3];
        longint dot, th, co16, eps16, num;
        longint unsigned l2, a, ls, r2;
        logic [127:0] qn;
        int k;
        bit above;
        t_cone_res r;
        v[0] = $signed(x);
        v[1] = $signed(y);
        v[2] = $signed(z);
        dot = 0;
        l2 = 0;
        for (int i = 0; i < 3; i++) begin
            if (op) v[i] -= longint'(light_pos[i]);
            d[i] = longint'($signed(spot_dir[16*i +: 16]));
            a = v[i] < 0 ? -v[i] : v[i];
            l2 += a * a;
            dot += v[i] * d[i];
        end
        r.inten = '0;
        r.cone = 1'b0;
        if (l2 == 0) return r;
        k = 0;
        while (k < 30 && (l2 >> (60 - 2 * k)) == 0) k++;
        ls = floor_sqrt(l2 << (2 * k));
        a = dot < 0 ? -dot : dot;
        qn = (128'(a) << (k + 2)) / 128'(ls);
        th = dot < 0 ? -longint'(qn[62:0]) : longint'(qn[62:0]);
        co16 = longint'(cos_out) * 4;
        eps16 = (longint'(cos_in) - longint'(cos_out)) * 4;
        above = th > co16;
        if (eps16 <= 0) begin
            r.inten = above ? FULL_SCALE : '0;
        end else begin
            num = th - co16;
            if (num <= 0) r.inten = '0;
            else if (num >= eps16) r.inten = FULL_SCALE;
            else r.inten = INT_W'((num << 16) / eps16);
        end
        r2 = longint'(lit_range) * longint'(lit_range);
        r.cone = (l2 <= r2) && above;
        return r;
    endfunction

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        case (idx)
            REG_LIGHT_POS_X: light_pos[0] = val[23:0];
            REG_LIGHT_POS_Y: light_pos[1] = val[23:0];
            REG_LIGHT_POS_Z: light_pos[2] = val[23:0];
            REG_SPOT_DIR:    spot_dir = val[47:0];
            REG_COS_INNER:   cos_in = val[15:0];
            REG_COS_OUTER:   cos_out = val[15:0];
            REG_LIGHT_RANGE: lit_range = val[22:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic set_light(logic [23:0] px, logic [23:0] py, logic [23:0] pz,
                             logic [47:0] dir, logic [15:0] ci, logic [15:0] co,
                             logic [22:0] rng);
        cfg_write(REG_LIGHT_POS_X, CFG_W'(px));
        cfg_write(REG_LIGHT_POS_Y, CFG_W'(py));
        cfg_write(REG_LIGHT_POS_Z, CFG_W'(pz));
        cfg_write(REG_SPOT_DIR, dir);
        cfg_write(REG_COS_INNER, CFG_W'(ci));
        cfg_write(REG_COS_OUTER, CFG_W'(co));
        cfg_write(REG_LIGHT_RANGE, CFG_W'(rng));
    endtask

    // offer one request, hold until taken, then idle per burst pattern
    task automatic send_vec(bit op, logic [23:0] x, logic [23:0] y, logic [23:0] z,
                            bit typed, t_cone_res typed_res, bit idle_ok);
        s_valid <= 1'b1;
        s_user  <= op;
        s_data  <= {z, y, x};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        cone_expect_q.push_back(typed ? typed_res : cone_falloff(op, x, y, z));
        items_sent++;
        if (idle_ok) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 30);
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (cone_expect_q.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic random_dir(output logic [47:0] dir);
        real c [3];
        real n;
        do begin
            for (int i = 0; i < 3; i++) c[i] = $itor($urandom_range(0, 2000)) - 1000.0;
            n = $sqrt(c[0] * c[0] + c[1] * c[1] + c[2] * c[2]);
        end while (n < 10.0);
        for (int i = 0; i < 3; i++) dir[16*i +: 16] = 16'($rtoi(c[i] / n * 16383.0));
    endtask

    task automatic random_vec(bit idle_ok);
        longint v [3];
        longint mag, nz;
        bit op;
        bit fits;
        op = $urandom_range(0, 1);
        if ($urandom_range(0, 9) < 7) begin
            mag = $urandom_range(0, 3) == 0 ? $urandom_range(1, 1 << 22)
                                            : $urandom_range(1, 1 << 17);
            nz = (mag >> $urandom_range(2, 8)) + 1;
            fits = 1'b1;
            for (int i = 0; i < 3; i++) begin
                v[i] = (longint'($signed(spot_dir[16*i +: 16])) * mag) >>> 14;
                v[i] += longint'($urandom_range(0, 2 * nz)) - nz;
                if (op) v[i] += longint'(light_pos[i]);
                if (v[i] > 8388607 || v[i] < -8388608) fits = 1'b0;
            end
            if (!fits) begin
                op = 1'b0;
                for (int i = 0; i < 3; i++)
                    v[i] = (longint'($signed(spot_dir[16*i +: 16])) * mag) >>> 14;
            end
            send_vec(op, v[0][23:0], v[1][23:0], v[2][23:0], 1'b0, '{0, 0}, idle_ok);
        end else begin
            send_vec(op, 24'($urandom), 24'($urandom), 24'($urandom), 1'b0, '{0, 0},
                     idle_ok);
        end
    endtask

    // receiver: random stall pattern plus long hold-offs on request
    always @(posedge i_clk) begin
        if (hold_tickets != hold_served) begin
            hold_served <= hold_served + 1;
            hold_cnt <= 400;
            m_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= $urandom_range(0, 99) >= stall_pct;
        end
    end

    always @(posedge i_clk) begin
        t_cone_res e;
        if (i_rst_n && m_valid && m_ready) begin
            results_seen++;
            if (cone_expect_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: intensity %0d in_cone %0b",
                             m_data[16:0], m_user);
            end else begin
                e = cone_expect_q.pop_front();
                if (m_data !== {7'd0, e.inten} || m_user !== e.cone) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected intensity %0d in_cone %0b, got %0d %0b",
                                 results_seen, e.inten, e.cone, m_data, m_user);
                end
            end
        end
    end

    localparam int N_DIRECTED = 14;
    t_stim_row directed_tab [N_DIRECTED] = '{
        '{0, 24'h0, 24'h0, 24'h0, 1, 17'd0, 0},
        '{1, 24'h0, 24'h0, 24'h0, 1, 17'd0, 0},
        '{0, 24'h0, -24'sd4096, 24'h0, 1, 17'h10000, 1},
        '{0, 24'h0, 24'sd4096, 24'h0, 1, 17'd0, 0},
        '{0, 24'h0, 24'h800000, 24'h0, 1, 17'h10000, 0},
        '{1, 24'h0, -24'sd4096, 24'h0, 1, 17'h10000, 1},
        '{0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 0, 17'd0, 0},
        '{0, 24'h800000, 24'h800000, 24'h800000, 0, 17'd0, 0},
        '{1, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 0, 17'd0, 0},
        '{0, 24'h000001, 24'hFFFFFF, 24'h000000, 0, 17'd0, 0},
        '{0, 24'sd300, -24'sd4096, 24'sd200, 0, 17'd0, 0},
        '{0, 24'sd1100, -24'sd4096, 24'h0, 0, 17'd0, 0},
        '{0, 24'h0, -24'sd102400, 24'h0, 0, 17'd0, 0},
        '{0, 24'h0, -24'sd102401, 24'h0, 0, 17'd0, 0}
    };

    initial begin
        logic [47:0] dir;
        logic [15:0] co, ci;
        light_pos = '{0, 0, 0};
        spot_dir = 48'd3221291008;
        cos_in = 16'sd15985;
        cos_out = 16'sd15624;
        lit_range = 23'd102400;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_tab[i])
            send_vec(directed_tab[i].op, directed_tab[i].x, directed_tab[i].y,
                     directed_tab[i].z, directed_tab[i].typed,
                     '{directed_tab[i].inten, directed_tab[i].cone}, 1'b0);
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_light(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 48'h7FFF_8000_7FFF,
                             16'hC000, 16'h4000, 23'd0);
                1: set_light(24'h800000, 24'h7FFFFF, 24'h800000, 48'h0000_0000_4000,
                             16'h4000, 16'hC000, 23'h7FFFFF);
                default: begin
                    random_dir(dir);
                    co = 16'($urandom_range(8000, 16200));
                    ci = $signed(co) + $urandom_range(0, 2200) - 200;
                    if ($signed(ci) > 16384) ci = 16'd16384;
                    set_light(24'($urandom), 24'($urandom_range(0, 1 << 16)),
                              24'($urandom), dir, ci, co, 23'($urandom_range(0, 1 << 20)));
                end
            endcase
            stall_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 30 : 70;
            if (ph == 2) hold_tickets++;
            for (int n = 0; n < 240; n++) random_vec(ph != 3);
            wait_drained();
        end

        repeat (100) @(posedge i_clk);
        $display("Sent %0d vectors over 7 light settings; %0d results checked.",
                 items_sent, results_seen);
        if (mismatches == 0 && cone_expect_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     cone_expect_q.size());
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Timed out with %0d results outstanding", cone_expect_q.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

FILE: spot_cone_intensity_top.f
+incdir+design
design/sci_pkg.sv
design/sci_front.sv
design/sci_sqrt_step.sv
design/sci_div_step.sv
design/spot_cone_intensity_top.sv
design/sci_chk.sv
bench/tb_spot_cone_intensity_top.sv
